// File: hdl/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants and controller/datapath interface types for the max-heap
// priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Default number of heap entries
  localparam int unsigned CAPACITY_DEF = 256;

  // Field widths
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CNT_OUT_W = 9;

  // Request opcodes (any other code behaves as a peek)
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch opcode and key of an accepted request
    logic set_err;     // flag the request as an error
    logic push_start;  // open a hole at the end, grow the count
    logic pop_start;   // shrink the count, fetch the last entry
    logic load_key;    // take the last entry as the moving key
    logic up_move;     // move the parent down into the hole
    logic down_move;   // move the larger child up into the hole
    logic place;       // write the moving key into the hole
    logic load_out;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            one;
    logic            up_gt;       // moving key beats its parent
    logic            up_at_root;  // parent of the hole is the root
    logic            down_go;     // larger child beats the moving key
  } sts_t;

endpackage

// File: hdl/mhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, and register both reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hdl/mhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Controller: sequences decode, sift-up, sift-down and result hand-off.
// ----------------------------------------------------------------------------
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECODE  = 7'b0000010,
    S_UP      = 7'b0000100,
    S_DOWN_LD = 7'b0001000,
    S_DOWN    = 7'b0010000,
    S_PLACE   = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_PUSH: begin
            if (sts_i.full) begin
              cmd_o.set_err = 1'b1;
              state_d       = S_FINISH;
            end else begin
              cmd_o.push_start = 1'b1;
              state_d          = sts_i.empty ? S_PLACE : S_UP;
            end
          end
          OP_POP: begin
            if (sts_i.empty) begin
              cmd_o.set_err = 1'b1;
              state_d       = S_FINISH;
            end else begin
              cmd_o.pop_start = 1'b1;
              state_d         = sts_i.one ? S_FINISH : S_DOWN_LD;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_UP: begin
        if (sts_i.up_gt) begin
          cmd_o.up_move = 1'b1;
          state_d       = sts_i.up_at_root ? S_PLACE : S_UP;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FINISH;
        end
      end
      S_DOWN_LD: begin
        cmd_o.load_key = 1'b1;
        state_d        = S_DOWN;
      end
      S_DOWN: begin
        if (sts_i.down_go) begin
          cmd_o.down_move = 1'b1;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FINISH;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        // Hand over once the result register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/mhpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_dp
// Datapath: heap store, hole position, moving key, count, root copy and
// result register.
// ----------------------------------------------------------------------------
module mhpq_dp
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [OP_W-1:0]             opcode_i,
  input  logic signed [KEY_W-1:0]     key_in_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  output logic signed [KEY_W-1:0]     top_key_o,
  output logic                        top_valid_o,
  output logic [CNT_OUT_W-1:0]        entry_count_o,
  output logic                        op_error_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = AW + 2;

  logic [CW-1:0]           cnt_q;
  logic [AW-1:0]           pos_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] root_q;
  logic [OP_W-1:0]         op_q;
  logic                    err_q;

  logic signed [KEY_W-1:0] res_key_q;
  logic                    res_valid_q;
  logic [CNT_OUT_W-1:0]    res_cnt_q;
  logic                    res_err_q;

  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           cnt_par;
  logic [AW-1:0]           pos_m1;
  logic [AW-1:0]           pos_par;
  logic [AW-1:0]           pos_par_m1;
  logic [AW-1:0]           pos_gpar;
  logic [PW-1:0]           cnt_w;
  logic [PW-1:0]           left_w;
  logic [PW-1:0]           right_w;
  logic                    have_l;
  logic                    have_r;
  logic                    pick_r;
  logic [PW-1:0]           child_w;
  logic signed [KEY_W-1:0] child_val;
  logic [PW-1:0]           next_l_w;
  logic [PW-1:0]           next_r_w;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [KEY_W-1:0]        wdata;
  logic [AW-1:0]           raddr_a;
  logic [AW-1:0]           raddr_b;
  logic [KEY_W-1:0]        rdata_a;
  logic [KEY_W-1:0]        rdata_b;
  logic signed [KEY_W-1:0] rd_a;
  logic signed [KEY_W-1:0] rd_b;

  assign rd_a = $signed(rdata_a);
  assign rd_b = $signed(rdata_b);

  // Index arithmetic: parents toward the root, children away from it
  assign cnt_m1     = cnt_q - CW'(1);
  assign cnt_par    = cnt_m1 >> 1;
  assign pos_m1     = pos_q - AW'(1);
  assign pos_par    = pos_m1 >> 1;
  assign pos_par_m1 = pos_par - AW'(1);
  assign pos_gpar   = pos_par_m1 >> 1;
  assign cnt_w      = PW'(cnt_q);
  assign left_w     = PW'({pos_q, 1'b1});
  assign right_w    = left_w + PW'(1);

  // Pick the larger child; the left one wins a tie
  assign have_l    = (left_w < cnt_w);
  assign have_r    = (right_w < cnt_w);
  assign pick_r    = have_r && (rd_b > rd_a);
  assign child_w   = pick_r ? right_w : left_w;
  assign child_val = pick_r ? rd_b : rd_a;
  assign next_l_w  = PW'({child_w[AW-1:0], 1'b1});
  assign next_r_w  = next_l_w + PW'(1);

  // Status toward the controller
  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.empty      = (cnt_q == '0);
    sts_o.full       = (cnt_q == CW'(CAPACITY));
    sts_o.one        = (cnt_q == CW'(1));
    sts_o.up_gt      = (key_q > rd_a);
    sts_o.up_at_root = (pos_par == '0);
    sts_o.down_go    = have_l && (child_val > key_q);
  end

  // Store write port: one source per cycle
  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = key_q;
    if (cmd_i.up_move) begin
      we    = 1'b1;
      wdata = rd_a;
    end else if (cmd_i.down_move) begin
      we    = 1'b1;
      wdata = child_val;
    end else if (cmd_i.place) begin
      we    = 1'b1;
    end
  end

  // Store read addresses for the next step
  always_comb begin
    raddr_a = pos_gpar;
    raddr_b = right_w[AW-1:0];
    if (cmd_i.push_start) begin
      raddr_a = cnt_par[AW-1:0];
    end else if (cmd_i.pop_start) begin
      raddr_a = cnt_m1[AW-1:0];
    end else if (cmd_i.load_key) begin
      raddr_a = AW'(1);
      raddr_b = PW'(2) < PW'(CAPACITY) ? AW'(2) : '0;
    end else if (cmd_i.down_move) begin
      raddr_a = next_l_w[AW-1:0];
      raddr_b = next_r_w[AW-1:0];
    end
  end

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.push_start) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.pop_start) begin
      cnt_q <= cnt_m1;
    end
  end

  // Request, hole and moving key; keep a copy of the root entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      key_q <= key_in_i;
      err_q <= 1'b0;
    end
    if (cmd_i.set_err) begin
      err_q <= 1'b1;
    end
    if (cmd_i.push_start) begin
      pos_q <= cnt_q[AW-1:0];
    end else if (cmd_i.pop_start) begin
      pos_q <= '0;
    end else if (cmd_i.up_move) begin
      pos_q <= pos_par;
    end else if (cmd_i.down_move) begin
      pos_q <= child_w[AW-1:0];
    end
    if (cmd_i.load_key) begin
      key_q <= rd_a;
    end
    if (we && (waddr == '0)) begin
      root_q <= $signed(wdata);
    end
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_q};

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_key_q   <= (cnt_q != '0) ? root_q : '0;
      res_valid_q <= (cnt_q != '0);
      res_cnt_q   <= cnt_ext[CNT_OUT_W-1:0];
      res_err_q   <= err_q;
    end
  end

  assign top_key_o     = res_key_q;
  assign top_valid_o   = res_valid_q;
  assign entry_count_o = res_cnt_q;
  assign op_error_o    = res_err_q;

endmodule

// File: hdl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed keys with push, pop and peek requests; every
// request returns the maximum, the count and an error flag.
//
//   channel  direction  handshake                fields
//   in       sink       in_valid_i / in_stall_o   opcode_i, key_in_i
//   out      source     out_valid_o / out_stall_i top_key_o, top_valid_o,
//                                                 entry_count_o, op_error_o
//
// One request at a time. A push climbs and a pop descends the heap one level
// per sift step, one store access per level. A peek, an error, a push into
// an empty heap and a pop of the last entry skip the sift loop.
// Reset clears the count; the store needs no clearing pass.
// A new request is taken while the previous result waits in the output
// register; a stalled output holds the next result in the finish step.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [KEY_W-1:0] key_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [KEY_W-1:0] top_key_o,
  output logic                    top_valid_o,
  output logic [CNT_OUT_W-1:0]    entry_count_o,
  output logic                    op_error_o
);

  cmd_t cmd;
  sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .key_in_i      (key_in_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .top_key_o     (top_key_o),
    .top_valid_o   (top_valid_o),
    .entry_count_o (entry_count_o),
    .op_error_o    (op_error_o)
  );

  // An empty heap reports a zero key
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_valid_o || (top_key_o == '0)))
    else $error("empty heap result carries a nonzero key");

  // Accepting a request closes the input until it is done
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after a request was taken");

  // At most one source drives the store write port
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.up_move, cmd.down_move, cmd.place}))
    else $error("conflicting store writes");

  // A request either starts a sift, an error, or neither - never two
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.push_start, cmd.pop_start, cmd.set_err}))
    else $error("conflicting request decode");

endmodule

// File: bench/mhpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_checker
// Watches the request and result channels of the max-heap priority queue.
// Each accepted request is applied to a local heap; the maximum, count, valid
// and error flags that follow are queued and compared field by field with the
// results in order of arrival. Failures and the number of results still owed
// are handed back to the test top.
// ----------------------------------------------------------------------------
module mhpq_checker
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [KEY_W-1:0] key_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [KEY_W-1:0] top_key_i,
  input  logic                    top_valid_i,
  input  logic [CNT_OUT_W-1:0]    entry_count_i,
  input  logic                    op_error_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct {
    logic signed [KEY_W-1:0] top_key;
    logic                    top_valid;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    op_error;
  } heap_view_t;

  // Local copy of the heap
  logic signed [KEY_W-1:0] heap_mem [CAPACITY];
  int unsigned             heap_fill;

  heap_view_t expected_views [$];
  int                      fails;

  // Apply one request to the local heap and return what the block must report
  function automatic heap_view_t apply_request(input logic [OP_W-1:0] op,
                                               input logic signed [KEY_W-1:0] key);
    heap_view_t              view;
    int unsigned             pos;
    int unsigned             parent;
    int unsigned             child;
    logic signed [KEY_W-1:0] tmp;
    view.op_error = 1'b0;
    case (op)
      OP_PUSH: begin
        if (heap_fill >= CAPACITY) begin
          view.op_error = 1'b1;
        end else begin
          // append, then climb past strictly smaller parents
          pos = heap_fill;
          heap_mem[pos] = key;
          heap_fill++;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_mem[pos] <= heap_mem[parent]) break;
            tmp              = heap_mem[pos];
            heap_mem[pos]    = heap_mem[parent];
            heap_mem[parent] = tmp;
            pos              = parent;
          end
        end
      end
      OP_POP: begin
        if (heap_fill == 0) begin
          view.op_error = 1'b1;
        end else begin
          heap_fill--;
          if (heap_fill > 0) begin
            // last entry to the root, then sink; ties favour the left child
            heap_mem[0] = heap_mem[heap_fill];
            pos = 0;
            forever begin
              child = 2 * pos + 1;
              if (child >= heap_fill) break;
              if (child + 1 < heap_fill && heap_mem[child + 1] > heap_mem[child])
                child++;
              if (heap_mem[child] <= heap_mem[pos]) break;
              tmp             = heap_mem[pos];
              heap_mem[pos]   = heap_mem[child];
              heap_mem[child] = tmp;
              pos             = child;
            end
          end
        end
      end
      default: ;  // peek and the spare code leave the heap alone
    endcase
    view.top_valid   = (heap_fill > 0);
    view.top_key     = (heap_fill > 0) ? heap_mem[0] : '0;
    view.entry_count = heap_fill[CNT_OUT_W-1:0];
    return view;
  endfunction

  // Check results first: a result never belongs to a request taken at the same edge
  always @(posedge clk_i) begin
    heap_view_t want;
    heap_view_t next_view;
    if (!rst_ni) begin
      heap_fill = 0;
      fails     = 0;
      expected_views.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          fails++;
          $display("%0t: result with no request outstanding: key %0d count %0d",
                   $time, top_key_i, entry_count_i);
        end else begin
          want = expected_views.pop_front();
          if (top_key_i !== want.top_key) begin
            fails++;
            $display("%0t: top_key expected %0d actual %0d", $time, want.top_key,
                     top_key_i);
          end
          if (top_valid_i !== want.top_valid) begin
            fails++;
            $display("%0t: top_valid expected %0b actual %0b", $time,
                     want.top_valid, top_valid_i);
          end
          if (entry_count_i !== want.entry_count) begin
            fails++;
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, entry_count_i);
          end
          if (op_error_i !== want.op_error) begin
            fails++;
            $display("%0t: op_error expected %0b actual %0b", $time,
                     want.op_error, op_error_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_view = apply_request(opcode_i, key_in_i);
        expected_views.insert(expected_views.size(), next_view);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_views.size();
  end

endmodule

// File: bench/max_heap_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_test
// Drives push, pop and peek requests into the max-heap priority queue: a
// directed opening on empty-heap errors, key extremes and equal keys, a full
// fill and drain, then random segments biased to grow, shrink or churn the
// heap. Both sides idle at random; the receiver twice holds off at length.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_test;
  import mhpq_pkg::*;

  localparam logic [OP_W-1:0]         OP_SPARE = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
  localparam int unsigned             REQ_TARGET = 1700;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         opcode_i;
  logic signed [KEY_W-1:0] key_in_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [KEY_W-1:0] top_key_o;
  logic                    top_valid_o;
  logic [CNT_OUT_W-1:0]    entry_count_o;
  logic                    op_error_o;

  int          fail_count;
  int          pending;
  int unsigned reqs_sent;
  bit          send_quiet;
  bit          recv_quiet;

  max_heap_priority_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .key_in_i      (key_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_key_o     (top_key_o),
    .top_valid_o   (top_valid_o),
    .entry_count_o (entry_count_o),
    .op_error_o    (op_error_o)
  );

  mhpq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .opcode_i      (opcode_i),
    .key_in_i      (key_in_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_key_i     (top_key_o),
    .top_valid_i   (top_valid_o),
    .entry_count_i (entry_count_o),
    .op_error_i    (op_error_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_req(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_in_i   <= key;
    do @(posedge clk_i); while (in_stall_o);
    reqs_sent++;
  endtask

  // Drop valid and hold until every owed result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mix of full-range keys, a narrow band for ties, and the extremes
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 8)) - 4;
    if (sel == 8) return KEY_MAX;
    return KEY_MIN;
  endfunction

  // Random requests, push_pct percent pushes, the rest mostly pops
  task automatic run_segment(input int unsigned len, input int unsigned push_pct);
    int unsigned r;
    logic [OP_W-1:0] op;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) op = OP_PUSH;
      else if (r < 95)  op = OP_POP;
      else if (r < 98)  op = OP_PEEK;
      else              op = OP_SPARE;
      send_req(op, pick_key());
    end
  endtask

  // Result side: random stall before each result, two long hold-offs
  initial begin
    int unsigned n;
    int unsigned results_taken;
    results_taken = 0;
    out_stall_i <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (results_taken == 120 || results_taken == 900) n = 400;
      else n = recv_quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      results_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned mode;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i   <= OP_PEEK;
    key_in_i   <= '0;
    reqs_sent  = 0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty heap: peek, pop error, spare code
    send_req(OP_PEEK, KEY_MAX);
    send_req(OP_POP, KEY_MIN);
    send_req(OP_SPARE, '1);
    // Extremes and a repeated maximum
    send_req(OP_PUSH, KEY_MIN);
    send_req(OP_PUSH, KEY_MAX);
    send_req(OP_PUSH, '0);
    send_req(OP_PUSH, -1);
    send_req(OP_PUSH, KEY_MAX);
    send_req(OP_PEEK, $urandom);
    send_req(OP_SPARE, $urandom);
    // Empty it out, then one pop too many
    repeat (6) send_req(OP_POP, $urandom);
    // Equal keys around a smaller one
    send_req(OP_PUSH, 7);
    send_req(OP_PUSH, 3);
    send_req(OP_PUSH, 7);
    send_req(OP_PUSH, 7);
    repeat (3) send_req(OP_POP, '0);

    // Fill past capacity, then drain past empty
    drain_results();
    run_segment(CAPACITY_DEF + 20, 100);
    send_quiet = 1'b1;
    run_segment(CAPACITY_DEF + 20, 0);
    send_quiet = 1'b0;

    // Random segments: grow, shrink or churn
    while (reqs_sent < REQ_TARGET) begin
      if ($urandom_range(0, 3) == 0) drain_results();
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 2);
      run_segment($urandom_range(40, 120), (mode == 0) ? 80 : (mode == 1) ? 15 : 50);
    end

    // Wait out the owed results and a little more
    drain_results();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("max_heap_priority_queue regression: pass");
    end else begin
      $display("max_heap_priority_queue regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("max_heap_priority_queue regression: fail");
    $finish;
  end

endmodule
